>>> rtl/core/pcl_pkg.sv
`default_nettype none

package pcl_pkg;

  localparam int CODE_W   = 48;
  localparam int SERIAL_W = 8;
  localparam int ENTRY_W  = CODE_W + SERIAL_W;

  localparam logic [2:0] REQ_LOGIN  = 3'd0;
  localparam logic [2:0] REQ_ADD    = 3'd1;
  localparam logic [2:0] REQ_EDIT   = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_LIST   = 3'd4;
  localparam logic [2:0] REQ_LOGOUT = 3'd5;

  localparam logic [3:0] ST_GRANTED = 4'd0;
  localparam logic [3:0] ST_WRONG   = 4'd1;
  localparam logic [3:0] ST_DENIED  = 4'd2;
  localparam logic [3:0] ST_DONE    = 4'd3;
  localparam logic [3:0] ST_FULL    = 4'd4;
  localparam logic [3:0] ST_EXISTS  = 4'd5;
  localparam logic [3:0] ST_BADIDX  = 4'd6;
  localparam logic [3:0] ST_EMPTY   = 4'd7;
  localparam logic [3:0] ST_NOLOGIN = 4'd8;
  localparam logic [3:0] ST_ENTRY   = 4'd9;

  localparam logic [CODE_W-1:0]   INIT_CODE0   = 48'h393837363534;
  localparam logic [CODE_W-1:0]   INIT_CODE1   = 48'h313233353234;
  localparam logic [SERIAL_W-1:0] INIT_SERIAL0 = 8'd1;
  localparam logic [SERIAL_W-1:0] INIT_SERIAL1 = 8'd2;
  localparam logic [SERIAL_W-1:0] INIT_NEXT_SERIAL = 8'd2;
  localparam logic [3:0]          INIT_MAX_TRIES   = 4'd3;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [CODE_W-1:0] code;
    logic [3:0]        user_index;
  } req_t;

  typedef struct packed {
    logic [3:0]          status;
    logic [2:0]          entry_slot;
    logic [CODE_W-1:0]   entry_code;
    logic [SERIAL_W-1:0] entry_serial;
    logic [3:0]          tries_left;
    logic [3:0]          entry_count;
    logic                last;
  } res_t;

  typedef enum logic [3:0] {
    S_INIT0,
    S_INIT1,
    S_IDLE,
    S_DECODE,
    S_SRD,
    S_SCMP,
    S_XRD,
    S_XCAP,
    S_DSH,
    S_DWR,
    S_LRD,
    S_LCAP,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/passcode_table_with_login.sv
// one request at a time; results leave through a one-entry output register
// login, add, edit scan: read (S_SRD) then compare (S_SCMP) per entry, up to a hit
// delete: entries above the index shift down; list: read, capture, emit per entry
// the next request is taken once the last result is in the output register
// reset: synchronous; a table load follows, no request taken meanwhile
// the table is one memory with a write port and a registered read
`default_nettype none

module passcode_table_with_login
  import pcl_pkg::*;
#(
  parameter int MAX_ENTRIES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire req_t       req_data,
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_t            res_data,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t state, state_next;

  req_t                req_r;
  logic [3:0]          max_tries;
  logic [CW-1:0]       valid_entries, valid_entries_next;
  logic [SERIAL_W-1:0] next_serial, next_serial_next;
  logic [3:0]          failed_tries, failed_tries_next;
  logic                session_open, session_open_next;
  logic [CW-1:0]       ptr, ptr_next;
  logic [3:0]          res_status, res_status_next;
  logic [2:0]          res_slot, res_slot_next;
  logic [CODE_W-1:0]   res_code, res_code_next;
  logic [SERIAL_W-1:0] res_serial, res_serial_next;
  logic                res_last, res_last_next;

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic                push_valid, push_ready;
  res_t                push_data;

  logic [CODE_W-1:0]   rd_code;
  logic [SERIAL_W-1:0] rd_serial;
  logic [CW-1:0]       ptr_inc, idx_slot;
  logic                scan_end, is_hit, tbl_empty, tbl_full, bad_idx, shift_more;
  logic [3:0]          fail_inc;
  logic                deny;
  logic [SERIAL_W-1:0] add_serial;

  assign req_ready  = (state == S_IDLE);
  assign rd_code    = rd_data[ENTRY_W-1:SERIAL_W];
  assign rd_serial  = rd_data[SERIAL_W-1:0];
  assign ptr_inc    = ptr + CW'(1);
  assign idx_slot   = CW'(req_r.user_index - 4'd1);
  assign scan_end   = (ptr >= valid_entries);
  assign is_hit     = (rd_code == req_r.code)
                      && !((req_r.req_type == REQ_EDIT) && (ptr == idx_slot));
  assign tbl_empty  = (valid_entries == '0);
  assign tbl_full   = (valid_entries >= CW'(MAX_ENTRIES));
  assign bad_idx    = (req_r.user_index == 4'd0)
                      || (8'(req_r.user_index) > 8'(valid_entries));
  assign shift_more = ((CW+1)'(ptr) + (CW+1)'(1)) < (CW+1)'(valid_entries);
  assign fail_inc   = failed_tries + 4'd1;
  assign deny       = (fail_inc >= max_tries) || (fail_inc == 4'd0);
  assign add_serial = next_serial + SERIAL_W'(1);

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT0: state_next = S_INIT1;
      S_INIT1: state_next = S_IDLE;
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (req_r.req_type)
          REQ_LOGIN: state_next = S_SRD;
          REQ_ADD: begin
            if (!session_open || tbl_full) state_next = S_EMIT;
            else state_next = S_SRD;
          end
          REQ_EDIT: begin
            if (!session_open || tbl_empty || bad_idx) state_next = S_EMIT;
            else state_next = S_SRD;
          end
          REQ_DELETE: begin
            if (!session_open || tbl_empty || bad_idx) state_next = S_EMIT;
            else state_next = S_XRD;
          end
          REQ_LIST: begin
            if (!session_open || tbl_empty) state_next = S_EMIT;
            else state_next = S_LRD;
          end
          REQ_LOGOUT: state_next = S_EMIT;
          default: state_next = S_IDLE;
        endcase
      end
      S_SRD: begin
        if (!scan_end) state_next = S_SCMP;
        else if (req_r.req_type == REQ_EDIT) state_next = S_XRD;
        else state_next = S_EMIT;
      end
      S_SCMP: begin
        if (is_hit) state_next = S_EMIT;
        else state_next = S_SRD;
      end
      S_XRD: state_next = S_XCAP;
      S_XCAP: begin
        if (req_r.req_type == REQ_DELETE) state_next = S_DSH;
        else state_next = S_EMIT;
      end
      S_DSH: begin
        if (shift_more) state_next = S_DWR;
        else state_next = S_EMIT;
      end
      S_DWR: state_next = S_DSH;
      S_LRD: state_next = S_LCAP;
      S_LCAP: state_next = S_EMIT;
      S_EMIT: begin
        if (push_ready) state_next = res_last ? S_IDLE : S_LRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    valid_entries_next = valid_entries;
    next_serial_next   = next_serial;
    failed_tries_next  = failed_tries;
    session_open_next  = session_open;
    ptr_next           = ptr;
    res_status_next    = res_status;
    res_slot_next      = res_slot;
    res_code_next      = res_code;
    res_serial_next    = res_serial;
    res_last_next      = res_last;
    mem_we             = 1'b0;
    mem_waddr          = ptr[IW-1:0];
    mem_wdata          = rd_data;
    mem_raddr          = ptr[IW-1:0];
    push_valid         = 1'b0;

    unique case (state)
      S_INIT0: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(0);
        mem_wdata = {INIT_CODE0, INIT_SERIAL0};
      end
      S_INIT1: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(1);
        mem_wdata = {INIT_CODE1, INIT_SERIAL1};
      end
      S_IDLE: ;
      S_DECODE: begin
        ptr_next        = '0;
        res_slot_next   = 3'd0;
        res_code_next   = '0;
        res_serial_next = '0;
        res_last_next   = 1'b1;
        res_status_next = ST_NOLOGIN;
        case (req_r.req_type)
          REQ_ADD: begin
            if (session_open) res_status_next = ST_FULL;
          end
          REQ_EDIT, REQ_DELETE: begin
            if (session_open) res_status_next = tbl_empty ? ST_EMPTY : ST_BADIDX;
          end
          REQ_LIST: begin
            if (session_open) res_status_next = ST_EMPTY;
          end
          REQ_LOGOUT: begin
            if (session_open) begin
              session_open_next = 1'b0;
              res_status_next   = ST_DONE;
            end
          end
          default: ;
        endcase
      end
      S_SRD: begin
        if (scan_end) begin
          case (req_r.req_type)
            REQ_LOGIN: begin
              failed_tries_next = deny ? 4'd0 : fail_inc;
              res_status_next   = deny ? ST_DENIED : ST_WRONG;
            end
            REQ_ADD: begin
              mem_we             = 1'b1;
              mem_waddr          = valid_entries[IW-1:0];
              mem_wdata          = {req_r.code, add_serial};
              next_serial_next   = add_serial;
              valid_entries_next = valid_entries + CW'(1);
              res_status_next    = ST_DONE;
              res_slot_next      = 3'(valid_entries);
              res_serial_next    = add_serial;
            end
            default: ;
          endcase
        end
      end
      S_SCMP: begin
        if (is_hit) begin
          if (req_r.req_type == REQ_LOGIN) begin
            session_open_next = 1'b1;
            failed_tries_next = 4'd0;
            res_status_next   = ST_GRANTED;
            res_slot_next     = 3'(ptr);
            res_serial_next   = rd_serial;
          end else begin
            res_status_next   = ST_EXISTS;
          end
        end else begin
          ptr_next = ptr_inc;
        end
      end
      S_XRD: begin
        mem_raddr = idx_slot[IW-1:0];
      end
      S_XCAP: begin
        res_status_next = ST_DONE;
        res_slot_next   = 3'(idx_slot);
        res_serial_next = rd_serial;
        ptr_next        = idx_slot;
        if (req_r.req_type == REQ_EDIT) begin
          mem_we    = 1'b1;
          mem_waddr = idx_slot[IW-1:0];
          mem_wdata = {req_r.code, rd_serial};
        end
      end
      S_DSH: begin
        mem_raddr = ptr_inc[IW-1:0];
        if (!shift_more) valid_entries_next = valid_entries - CW'(1);
      end
      S_DWR: begin
        mem_we   = 1'b1;
        ptr_next = ptr_inc;
      end
      S_LRD: ;
      S_LCAP: begin
        res_status_next = ST_ENTRY;
        res_slot_next   = 3'(ptr);
        res_code_next   = rd_code;
        res_serial_next = rd_serial;
        res_last_next   = (ptr_inc == valid_entries);
      end
      S_EMIT: begin
        push_valid = 1'b1;
        if (push_ready && !res_last) ptr_next = ptr_inc;
      end
      default: ;
    endcase
  end

  always_comb begin
    push_data.status       = res_status;
    push_data.entry_slot   = res_slot;
    push_data.entry_code   = res_code;
    push_data.entry_serial = res_serial;
    push_data.tries_left   = (max_tries > failed_tries) ? (max_tries - failed_tries) : 4'd0;
    push_data.entry_count  = 4'(valid_entries);
    push_data.last         = res_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT0;
      max_tries     <= INIT_MAX_TRIES;
      valid_entries <= CW'(2);
      next_serial   <= INIT_NEXT_SERIAL;
      failed_tries  <= 4'd0;
      session_open  <= 1'b0;
    end else begin
      state         <= state_next;
      valid_entries <= valid_entries_next;
      next_serial   <= next_serial_next;
      failed_tries  <= failed_tries_next;
      session_open  <= session_open_next;
      if (cfg_we) max_tries <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req_r <= req_data;
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_code   <= res_code_next;
    res_serial <= res_serial_next;
    res_last   <= res_last_next;
  end

  pcl_res_buf u_res_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_entries <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && push_ready && res_last |=> state == S_IDLE)
    else $error("final result did not end the request");

  a_logout_only: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(session_open) |->
      $past(state) == S_DECODE && $past(req_r.req_type) == REQ_LOGOUT)
    else $error("session closed without logout");

endmodule

`default_nettype wire

>>> rtl/core/pcl_res_buf.sv
`default_nettype none

module pcl_res_buf
  import pcl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire res_t push_data,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res_data
);

  logic full;
  res_t data;

  assign push_ready = !full || res_ready;
  assign res_valid  = full;
  assign res_data   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push_ready) begin
      full <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      data <= push_data;
    end
  end

endmodule

`default_nettype wire
